>>> rtl/depth_to_heatmap_color_defines.svh
// assertion helpers for the depth heatmap block
`ifndef DEPTH_TO_HEATMAP_COLOR_DEFINES_SVH
`define DEPTH_TO_HEATMAP_COLOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DTHC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("depth heatmap check failed");

// next-cycle implication, checked outside reset
`define DTHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("depth heatmap check failed");

`endif

>>> rtl/dthc_pkg.sv
`timescale 1ns / 1ps
package dthc_pkg;

  // field widths
  localparam int DEPTH_W = 16;
  localparam int CFG_W   = 16;
  localparam int CHAN_W  = 8;
  localparam int PROD_W  = 32;

  // distances in micrometres below 2^26 for any mm register value
  localparam int UM_W    = 26;
  localparam int UM_PER_MM = 1000;

  // position t in Q16
  localparam int Q_BITS  = 16;
  localparam int T_W     = Q_BITS + 1;
  localparam int X_W     = Q_BITS + 2;

  // one quotient bit per divider stage
  localparam int DIV_STEPS = Q_BITS;

  // register indexes
  typedef enum logic [1:0] {
    REG_UNIT    = 2'd0,
    REG_NEAR    = 2'd1,
    REG_FAR     = 2'd2,
    REG_INVALID = 2'd3
  } dthc_reg_t;

  // classification that travels with each word through the divider
  typedef struct packed {
    logic invalid;  // black pixel
    logic zero;     // t = 0
    logic sat;      // t = 1
  } dthc_tag_t;

endpackage

>>> rtl/dthc_if.sv
`timescale 1ns / 1ps
// depth sample channel
interface dthc_in_if import dthc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] raw_depth;

  modport source (output valid, output raw_depth, input ready);
  modport sink   (input valid, input raw_depth, output ready);
endinterface

// heatmap pixel channel
interface dthc_out_if import dthc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              invalid;

  modport source (output valid, output red, output green, output blue, output invalid,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input invalid,
                  output ready);
endinterface

>>> rtl/dthc_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per stage: q = floor(diff * 2^16 / den)
module dthc_div import dthc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  dthc_tag_t         in_tag,
  input  logic [UM_W-1:0]   in_diff,
  input  logic [UM_W-1:0]   in_den,
  output logic              out_valid,
  output dthc_tag_t         out_tag,
  output logic [Q_BITS-1:0] out_q
);

  logic              v_r   [DIV_STEPS];
  dthc_tag_t         tag_r [DIV_STEPS];
  logic [UM_W-1:0]   rem_r [DIV_STEPS];
  logic [UM_W-1:0]   den_r [DIV_STEPS];
  logic [Q_BITS-1:0] q_r   [DIV_STEPS];

  logic [UM_W-1:0]   rem_nxt [DIV_STEPS];
  logic [Q_BITS-1:0] q_nxt   [DIV_STEPS];
  logic [UM_W-1:0]   rem_prev [DIV_STEPS];
  logic [UM_W-1:0]   den_prev [DIV_STEPS];
  logic [Q_BITS-1:0] q_prev   [DIV_STEPS];
  logic [UM_W:0]     shifted  [DIV_STEPS];
  logic              take     [DIV_STEPS];

  // per-stage shift, compare and subtract
  always_comb begin
    rem_prev[0] = in_diff;
    den_prev[0] = in_den;
    q_prev[0]   = '0;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_prev[k] = rem_r[k-1];
      den_prev[k] = den_r[k-1];
      q_prev[k]   = q_r[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      shifted[k] = {rem_prev[k], 1'b0};
      take[k]    = (shifted[k] >= {1'b0, den_prev[k]});
      rem_nxt[k] = take[k] ? UM_W'(shifted[k] - {1'b0, den_prev[k]}) : UM_W'(shifted[k]);
      q_nxt[k]   = {q_prev[k][Q_BITS-2:0], take[k]};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STEPS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < DIV_STEPS; k++) v_r[k] <= v_r[k-1];
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      for (int k = 1; k < DIV_STEPS; k++) tag_r[k] <= tag_r[k-1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        den_r[k] <= den_prev[k];
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS-1];
  assign out_tag   = tag_r[DIV_STEPS-1];
  assign out_q     = q_r[DIV_STEPS-1];

endmodule

>>> rtl/depth_to_heatmap_color.sv
`timescale 1ns / 1ps
// channel   dir  handshake       payload
// in_ch     in   valid / ready   raw_depth[15:0]
// out_ch    out  valid / ready   red[7:0] green[7:0] blue[7:0] invalid
// cfg       in   cfg_we          cfg_index[1:0] cfg_wdata[15:0]
//
// one word per clock unless out_ch stalls; stages from acceptance to out_ch.valid:
// input register, 16x16 multiply, range classify, 16 divider stages (one quotient
// bit each), segment select, color output register.
// rst_n is synchronous; it clears the valid bits and loads the register defaults.
// a stall at out_ch freezes every stage at once, so in_ch.ready follows out_ch.ready
// whenever the output register is full.
`include "depth_to_heatmap_color_defines.svh"
module depth_to_heatmap_color import dthc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dthc_in_if.sink           in_ch,
  dthc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  dthc_reg_t         cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [CFG_W-1:0] unit_um_r, near_mm_r, far_mm_r, invalid_um_r;
  logic [UM_W-1:0]  near_um_r, far_um_r, den_um_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_um_r    <= CFG_W'(1000);
      near_mm_r    <= CFG_W'(300);
      far_mm_r     <= CFG_W'(10000);
      invalid_um_r <= CFG_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UNIT:    unit_um_r    <= cfg_wdata;
        REG_NEAR:    near_mm_r    <= cfg_wdata;
        REG_FAR:     far_mm_r     <= cfg_wdata;
        REG_INVALID: invalid_um_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // distances in micrometres, settled well before a word reaches the classify stage
  always_ff @(posedge clk) begin
    near_um_r <= UM_W'(near_mm_r * UM_W'(UM_PER_MM));
    far_um_r  <= UM_W'(far_mm_r * UM_W'(UM_PER_MM));
    den_um_r  <= UM_W'(far_um_r - near_um_r);
  end

  // global advance: move unless the output word is held
  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: input register
  logic               s1_v_r;
  logic [DEPTH_W-1:0] s1_raw_r;
  // stage 2: distance
  logic               s2_v_r;
  logic [PROD_W-1:0]  s2_d_r;
  // stage 3: classify and divider operands
  logic               s3_v_r;
  dthc_tag_t          s3_tag_r;
  logic [UM_W-1:0]    s3_diff_r;
  logic [UM_W-1:0]    s3_den_r;
  dthc_tag_t          s3_tag_nxt;
  // quotient pipeline
  logic               div_v;
  dthc_tag_t          div_tag;
  logic [Q_BITS-1:0]  div_q;
  // stage 4: segment and fraction
  logic               s4_v_r;
  logic               s4_invalid_r;
  logic [1:0]         s4_seg_r;
  logic [T_W-1:0]     s4_f_r;
  // output register
  logic               out_v_r;
  logic [CHAN_W-1:0]  red_r, green_r, blue_r;
  logic               invalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_ch.valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= div_v;
      out_v_r <= s4_v_r;
    end
  end

  // range classification
  always_comb begin
    s3_tag_nxt.invalid = (s2_d_r <= PROD_W'(invalid_um_r));
    s3_tag_nxt.zero    = (s2_d_r <= PROD_W'(near_um_r));
    s3_tag_nxt.sat     = (s2_d_r >= PROD_W'(far_um_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_raw_r  <= in_ch.raw_depth;
      s2_d_r    <= PROD_W'(s1_raw_r) * PROD_W'(unit_um_r);
      s3_tag_r  <= s3_tag_nxt;
      s3_diff_r <= UM_W'(s2_d_r - PROD_W'(near_um_r));
      s3_den_r  <= den_um_r;
    end
  end

  dthc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_tag    (s3_tag_r),
    .in_diff   (s3_diff_r),
    .in_den    (s3_den_r),
    .out_valid (div_v),
    .out_tag   (div_tag),
    .out_q     (div_q)
  );

  // position, segment and fraction
  logic [T_W-1:0] t_val;
  logic [X_W-1:0] x_val;
  logic [1:0]     seg_val;
  logic [T_W-1:0] f_val;

  always_comb begin
    priority if (div_tag.zero) begin
      t_val = '0;
    end else if (div_tag.sat) begin
      t_val = T_W'(1) << Q_BITS;
    end else begin
      t_val = {1'b0, div_q};
    end
    x_val   = X_W'(t_val) + (X_W'(t_val) << 1);
    seg_val = (x_val[X_W-1:Q_BITS] > 2'd2) ? 2'd2 : x_val[X_W-1:Q_BITS];
    f_val   = T_W'(x_val - (X_W'(seg_val) << Q_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_invalid_r <= div_tag.invalid;
      s4_seg_r     <= seg_val;
      s4_f_r       <= f_val;
    end
  end

  // ramps: floor(f * 255 / 2^16) as (f << 8) - f
  localparam int RAMP_W = T_W + CHAN_W;
  logic [T_W-1:0]    f_down;
  logic [RAMP_W-1:0] up_prod, down_prod;
  logic [CHAN_W-1:0] ramp_up, ramp_down;
  logic [CHAN_W-1:0] red_nxt, green_nxt, blue_nxt;

  always_comb begin
    f_down    = T_W'((T_W'(1) << Q_BITS) - s4_f_r);
    up_prod   = (RAMP_W'(s4_f_r) << CHAN_W) - RAMP_W'(s4_f_r);
    down_prod = (RAMP_W'(f_down) << CHAN_W) - RAMP_W'(f_down);
    ramp_up   = up_prod[Q_BITS +: CHAN_W];
    ramp_down = down_prod[Q_BITS +: CHAN_W];
    if (s4_invalid_r) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else begin
      unique case (s4_seg_r)
        2'd0: begin
          red_nxt   = '1;
          green_nxt = ramp_up;
          blue_nxt  = '0;
        end
        2'd1: begin
          red_nxt   = ramp_down;
          green_nxt = '1;
          blue_nxt  = '0;
        end
        default: begin
          red_nxt   = '0;
          green_nxt = ramp_down;
          blue_nxt  = ramp_up;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r     <= red_nxt;
      green_r   <= green_nxt;
      blue_r    <= blue_nxt;
      invalid_r <= s4_invalid_r;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.red     = red_r;
  assign out_ch.green   = green_r;
  assign out_ch.blue    = blue_r;
  assign out_ch.invalid = invalid_r;

  // checks
  `DTHC_ASSERT_IMPL(a_invalid_black, out_ch.valid && out_ch.invalid,
                    out_ch.red == '0 && out_ch.green == '0 && out_ch.blue == '0)
  `DTHC_ASSERT_IMPL(a_stall_blocks_input, out_ch.valid && !out_ch.ready, !in_ch.ready)
  `DTHC_ASSERT_IMPL(a_ramp_shape, out_ch.valid && !out_ch.invalid,
                    out_ch.red == '1 || out_ch.green == '1 || out_ch.red == '0)

endmodule

>>> test/depth_to_heatmap_color_test.sv
`timescale 1ns / 1ps
module depth_to_heatmap_color_test;
  import dthc_pkg::*;

  localparam int PHASE_ITEMS = 103;
  localparam int HOLD_AT     = 40;   // result count at which the sink holds off
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 25;

  // corner depths for the reset configuration (near 0.3 m, far 10 m, unit 1 mm)
  localparam logic [DEPTH_W-1:0] CORNER_DEPTHS [17] = '{
    16'd0, 16'd1, 16'd2, 16'd299, 16'd300, 16'd301, 16'd3533, 16'd3534,
    16'd6766, 16'd6767, 16'd9999, 16'd10000, 16'd10001, 16'hFFFF,
    16'hAAAA, 16'h5555, 16'h8000
  };

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              invalid;
  } heat_pixel_t;

  // expected heatmap pixels and the register copy they are computed from
  class heatmap_check;
    logic [CFG_W-1:0] unit_um;
    logic [CFG_W-1:0] near_mm;
    logic [CFG_W-1:0] far_mm;
    logic [CFG_W-1:0] invalid_um;
    heat_pixel_t      expected_pixels[$];
    int               errors;

    function new();
      unit_um    = 16'd1000;
      near_mm    = 16'd300;
      far_mm     = 16'd10000;
      invalid_um = 16'd1000;
      errors     = 0;
    endfunction

    function void set_config(logic [CFG_W-1:0] unit, logic [CFG_W-1:0] near,
                             logic [CFG_W-1:0] far, logic [CFG_W-1:0] inval);
      unit_um    = unit;
      near_mm    = near;
      far_mm     = far;
      invalid_um = inval;
    endfunction

    // depth -> position in Q16 -> three-segment color ramp
    function heat_pixel_t color_of(logic [DEPTH_W-1:0] raw);
      logic [63:0] depth_um, near_um, far_um, pos, x, seg, frac, up, down;
      heat_pixel_t px;
      depth_um = 64'(raw) * 64'(unit_um);
      near_um  = 64'(near_mm) * 64'(UM_PER_MM);
      far_um   = 64'(far_mm) * 64'(UM_PER_MM);
      px       = '0;
      if (depth_um <= 64'(invalid_um)) begin
        px.invalid = 1'b1;
        return px;
      end
      if (depth_um <= near_um) pos = 64'd0;
      else if (depth_um >= far_um) pos = 64'd65536;
      else pos = ((depth_um - near_um) << 16) / (far_um - near_um);
      x   = 64'd3 * pos;
      seg = x >> 16;
      if (seg > 64'd2) seg = 64'd2;
      frac = x - (seg << 16);
      up   = (frac * 64'd255) >> 16;
      down = ((64'd65536 - frac) * 64'd255) >> 16;
      case (seg)
        64'd0: begin
          px.red = 8'd255; px.green = up[7:0]; px.blue = 8'd0;
        end
        64'd1: begin
          px.red = down[7:0]; px.green = 8'd255; px.blue = 8'd0;
        end
        default: begin
          px.red = 8'd0; px.green = down[7:0]; px.blue = up[7:0];
        end
      endcase
      return px;
    endfunction

    function void note_depth(logic [DEPTH_W-1:0] raw);
      expected_pixels.push_back(color_of(raw));
    endfunction

    function void check_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] b, logic inv);
      heat_pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("pixel with none expected: red %0d green %0d blue %0d invalid %0d",
               r, g, b, inv);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (r !== want.red) begin
        $error("red: expected %0d, actual %0d", want.red, r);
        errors++;
      end
      if (g !== want.green) begin
        $error("green: expected %0d, actual %0d", want.green, g);
        errors++;
      end
      if (b !== want.blue) begin
        $error("blue: expected %0d, actual %0d", want.blue, b);
        errors++;
      end
      if (inv !== want.invalid) begin
        $error("invalid: expected %0d, actual %0d", want.invalid, inv);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  dthc_reg_t        cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  dthc_in_if  in_ch ();
  dthc_out_if out_ch ();

  heatmap_check chk = new();

  depth_to_heatmap_color u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // raw depth aimed at the ramp, the invalid threshold, or anywhere
  function automatic logic [DEPTH_W-1:0] pick_depth();
    logic [63:0] unit, near_um, far_um, lo, hi, span, target, raw;
    unit    = 64'(chk.unit_um);
    near_um = 64'(chk.near_mm) * 64'(UM_PER_MM);
    far_um  = 64'(chk.far_mm) * 64'(UM_PER_MM);
    if (unit == 64'd0) return DEPTH_W'($urandom);
    case ($urandom_range(0, 5))
      0: return DEPTH_W'($urandom);
      1: begin
        raw = 64'(chk.invalid_um) / unit + 64'($urandom_range(0, 2));
        if (raw != 64'd0) raw = raw - 64'd1;
      end
      default: begin
        lo     = (near_um < far_um) ? near_um : far_um;
        hi     = (near_um < far_um) ? far_um : near_um;
        span   = hi - lo + 64'd2000;
        target = lo + 64'($urandom_range(0, 32'(span + span / 4)));
        if ($urandom_range(0, 3) == 0 && target >= span / 8) target = target - span / 8;
        raw = target / unit;
      end
    endcase
    if (raw > 64'hFFFF) raw = 64'hFFFF;
    return raw[DEPTH_W-1:0];
  endfunction

  // offer one depth word and wait for it to be taken
  task automatic send_depth(input logic [DEPTH_W-1:0] raw, input bit gapless);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.raw_depth <= raw;
    do @(posedge clk); while (!in_ch.ready);
    chk.note_depth(raw);
  endtask

  // write all four registers back to back
  task automatic load_config(input logic [CFG_W-1:0] unit, input logic [CFG_W-1:0] near,
                             input logic [CFG_W-1:0] far, input logic [CFG_W-1:0] inval);
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNIT;
    cfg_wdata <= unit;
    @(posedge clk);
    cfg_index <= REG_NEAR;
    cfg_wdata <= near;
    @(posedge clk);
    cfg_index <= REG_FAR;
    cfg_wdata <= far;
    @(posedge clk);
    cfg_index <= REG_INVALID;
    cfg_wdata <= inval;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.set_config(unit, near, far, inval);
  endtask

  // stop offering and let every expected pixel come out
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] unit, input logic [CFG_W-1:0] near,
                           input logic [CFG_W-1:0] far, input logic [CFG_W-1:0] inval);
    bit gapless;
    load_config(unit, near, far, inval);
    gapless = ($urandom_range(0, 2) == 0);
    repeat (PHASE_ITEMS) send_depth(pick_depth(), gapless);
    finish_phase();
  endtask

  // pixel sink: random stalls, calm stretches, one long hold-off
  initial begin : drain_pixels
    int stall;
    int seen;
    out_ch.ready <= 1'b0;
    seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (seen == HOLD_AT) stall = HOLD_CYCLES;
      else if ((seen / 64) % 2 == 1) stall = 0;
      else stall = $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      chk.check_pixel(out_ch.red, out_ch.green, out_ch.blue, out_ch.invalid);
      seen++;
    end
  end

  initial begin : stimulus
    int near_r;
    int far_r;
    in_ch.valid     <= 1'b0;
    in_ch.raw_depth <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_UNIT;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: corners, then a back-to-back stream so the hold-off backs up
    for (int i = 0; i < 17; i++) send_depth(CORNER_DEPTHS[i], 1'b1);
    repeat (PHASE_ITEMS) send_depth(pick_depth(), 1'b1);
    finish_phase();

    // smallest unit and narrowest ramp
    run_phase(16'd1, 16'd0, 16'd1, 16'd0);
    // all registers at maximum, far equal to near
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // zero unit, every pixel black
    run_phase(16'd0, 16'd100, 16'd200, 16'd0);
    // far below near
    run_phase(16'd7, 16'd5000, 16'd100, 16'd500);
    // widest ramp
    run_phase(16'd1000, 16'd0, 16'hFFFF, 16'd0);
    // fully random registers
    run_phase(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom), CFG_W'($urandom),
              CFG_W'($urandom));
    // random but well-ordered registers
    near_r = $urandom_range(0, 2000);
    far_r  = near_r + $urandom_range(1, 20000);
    run_phase(CFG_W'($urandom_range(1, 2000)), CFG_W'(near_r), CFG_W'(far_r),
              CFG_W'($urandom_range(0, 5000)));
    // back to the defaults
    run_phase(16'd1000, 16'd300, 16'd10000, 16'd1000);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("** depth_to_heatmap_color: PASSED **");
    end else begin
      $display("** depth_to_heatmap_color: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #5_000_000;
    $display("** depth_to_heatmap_color: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/dthc_pkg.sv
rtl/dthc_if.sv
rtl/dthc_div.sv
rtl/depth_to_heatmap_color.sv
test/depth_to_heatmap_color_test.sv
